>>> hdl/savn_pkg.sv
package savn_pkg;

  localparam int TimeW = 32;
  localparam int CoordW = 16;
  localparam int NormW = 16;
  localparam int LenW = 9;
  localparam int SqrtSteps = 16;
  localparam logic [LenW-1:0] LenReset = 9'd4;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } savn_op_t;

  typedef struct packed {
    logic     start;
    savn_op_t op;
  } savn_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULX,
    ST_MULY,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_UPDATE,
    ST_DIVT_GO,
    ST_DIVT_WAIT,
    ST_DIVN_GO,
    ST_DIVN_WAIT,
    ST_OUT
  } savn_state_t;

endpackage

>>> hdl/savn_ring.sv
module savn_ring import savn_pkg::*; #(
  parameter int AW = 8,
  parameter int DEPTH = 256,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/savn_alu.sv
module savn_alu import savn_pkg::*; #(
  parameter int DW = 40,
  parameter int NW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  savn_cmd_t     cmd,
  input  logic [DW-1:0] operand,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int RW = (NW + 2 > 19) ? NW + 2 : 19;
  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  savn_op_t      op;
  logic [DW-1:0] dreg;
  logic [RW-1:0] rem;
  logic [NW-1:0] dvsr;
  logic [RW-1:0] shifted;
  logic [RW-1:0] sub;
  logic [RW:0]   diff;
  logic          ge;

  always_comb begin
    unique case (op)
      OP_SQRT: begin
        shifted = {rem[RW-3:0], dreg[DW-1:DW-2]};
        sub = RW'({quotient[NormW-1:0], 2'b01});
      end
      OP_DIV: begin
        shifted = {rem[RW-2:0], dreg[DW-1]};
        sub = RW'(dvsr);
      end
      default: begin
        shifted = '0;
        sub = '0;
      end
    endcase
    diff = {1'b0, shifted} - {1'b0, sub};
    ge = !diff[RW];
  end

  assign done = busy && (cnt == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt <= (cmd.op == OP_SQRT) ? CW'(SqrtSteps) : CW'(DW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op <= cmd.op;
      dreg <= operand;
      dvsr <= divisor;
      rem <= '0;
      quotient <= '0;
    end else if (busy) begin
      rem <= ge ? diff[RW-1:0] : shifted;
      quotient <= {quotient[DW-2:0], ge};
      dreg <= (op == OP_SQRT) ? {dreg[DW-3:0], 2'b00} : {dreg[DW-2:0], 1'b0};
    end
  end

endmodule

>>> hdl/sliding_average_of_vector_norm.sv
// Moving average of the integer norm floor(sqrt(x*x + y*y)) of 2-D samples.
// Input channel: in_valid/in_stall with time_stamp, coord_x, coord_y; a word
// is taken when in_valid is high and in_stall is low. Output channel:
// out_valid/out_stall with mean_time, mean_norm, held in an output register.
// Config: cfg_we writes cfg_data into window_len and restarts the window;
// write only while the block is idle.
// One sample at a time runs through a single shared step unit: a 16-step
// square root, then, when the window is full, two restoring divisions of
// DW = 32 + clog2(WINDOW_MAX) steps each. A new sample is accepted only
// once the last one is through, and a sample with a result raises out_valid
// once both divisions are done and the output register is free.
// After reset or a config write, the first n_eff - 1 samples give no word.
// Reset restores window_len to 4 and clears sums, position and fill count;
// the ring memory keeps its contents and needs no clearing pass.
// A stalled output word holds; the next sample may be accepted and worked
// on meanwhile, and its result waits until the output register frees.
module sliding_average_of_vector_norm import savn_pkg::*; #(
  parameter int WINDOW_MAX = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [LenW-1:0]          cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [TimeW-1:0]         time_stamp,
  input  logic signed [CoordW-1:0] coord_x,
  input  logic signed [CoordW-1:0] coord_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [TimeW-1:0]         mean_time,
  output logic [NormW-1:0]         mean_norm
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int NW = $clog2(WINDOW_MAX + 1);
  localparam int DW = TimeW + AW;
  localparam int NSW = NormW + AW;
  localparam int RDW = TimeW + NormW;

  savn_state_t state, state_next;
  savn_cmd_t   cmd;

  logic [LenW-1:0]   window_len;
  logic [NW-1:0]     n_eff;
  logic [DW-1:0]     time_sum;
  logic [NSW-1:0]    norm_sum;
  logic [AW-1:0]     write_pos;
  logic [NW-1:0]     fill_count;
  logic              full;
  logic [TimeW-1:0]  t_reg;
  logic [CoordW-1:0] ax;
  logic [CoordW-1:0] ay;
  logic [CoordW-1:0] mul_in;
  logic [31:0]       acc;
  logic [31:0]       prod;
  logic [TimeW-1:0]  mt_hold;
  logic [DW-1:0]     operand;
  logic              alu_done;
  logic [DW-1:0]     quotient;
  logic              ring_re;
  logic              ring_we;
  logic [RDW-1:0]    ring_rdata;
  logic              has_result;
  logic              out_free;

  function automatic logic [CoordW-1:0] magnitude(input logic [CoordW-1:0] v);
    return v[CoordW-1] ? (~v + CoordW'(1)) : v;
  endfunction

  always_comb begin
    if (window_len == '0) begin
      n_eff = NW'(1);
    end else if (32'(window_len) > 32'(WINDOW_MAX)) begin
      n_eff = NW'(WINDOW_MAX);
    end else begin
      n_eff = NW'(window_len);
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign has_result = full || (32'(fill_count) + 32'd1 == 32'(n_eff));
  assign mul_in = (state == ST_MULX) ? ax : ay;
  assign prod = 32'(mul_in) * 32'(mul_in);

  savn_alu #(
    .DW(DW),
    .NW(NW)
  ) u_alu (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .operand (operand),
    .divisor (n_eff),
    .done    (alu_done),
    .quotient(quotient)
  );

  savn_ring #(
    .AW    (AW),
    .DEPTH (WINDOW_MAX),
    .DATA_W(RDW)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(write_pos),
    .wdata({t_reg, quotient[NormW-1:0]}),
    .re   (ring_re),
    .raddr(write_pos),
    .rdata(ring_rdata)
  );

  always_comb begin
    state_next = state;
    cmd.start = 1'b0;
    cmd.op = OP_DIV;
    operand = '0;
    ring_re = 1'b0;
    ring_we = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ring_re = 1'b1;
          state_next = ST_MULX;
        end
      end
      ST_MULX: state_next = ST_MULY;
      ST_MULY: state_next = ST_SQRT_GO;
      ST_SQRT_GO: begin
        cmd.start = 1'b1;
        cmd.op = OP_SQRT;
        operand = {acc, {AW{1'b0}}};
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (alu_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ring_we = 1'b1;
        state_next = has_result ? ST_DIVT_GO : ST_IDLE;
      end
      ST_DIVT_GO: begin
        cmd.start = 1'b1;
        operand = time_sum;
        state_next = ST_DIVT_WAIT;
      end
      ST_DIVT_WAIT: begin
        if (alu_done) begin
          state_next = ST_DIVN_GO;
        end
      end
      ST_DIVN_GO: begin
        cmd.start = 1'b1;
        operand = DW'(norm_sum);
        state_next = ST_DIVN_WAIT;
      end
      ST_DIVN_WAIT: begin
        if (alu_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LenReset;
      time_sum <= '0;
      norm_sum <= '0;
      write_pos <= '0;
      fill_count <= '0;
      full <= 1'b0;
    end else if (cfg_we) begin
      window_len <= cfg_data;
      time_sum <= '0;
      norm_sum <= '0;
      write_pos <= '0;
      fill_count <= '0;
      full <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            full <= (fill_count == n_eff);
          end
        end
        ST_MULX: begin
          if (full) begin
            time_sum <= time_sum - DW'(ring_rdata[RDW-1:NormW]);
            norm_sum <= norm_sum - NSW'(ring_rdata[NormW-1:0]);
          end
        end
        ST_UPDATE: begin
          time_sum <= time_sum + DW'(t_reg);
          norm_sum <= norm_sum + NSW'(quotient[NormW-1:0]);
          if (!full) begin
            fill_count <= fill_count + NW'(1);
          end
          if (32'(write_pos) + 32'd1 >= 32'(n_eff)) begin
            write_pos <= '0;
          end else begin
            write_pos <= write_pos + AW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      t_reg <= time_stamp;
      ax <= magnitude(coord_x);
      ay <= magnitude(coord_y);
    end
    if (state == ST_MULX) begin
      acc <= prod;
    end else if (state == ST_MULY) begin
      acc <= acc + prod;
    end
    if (state == ST_DIVN_GO) begin
      mt_hold <= quotient[TimeW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      mean_time <= mt_hold;
      mean_norm <= quotient[NormW-1:0];
    end
  end

endmodule

>>> dv/sliding_average_of_vector_norm_tb.sv
module sliding_average_of_vector_norm_tb;
  import savn_pkg::*;

  localparam int WindowMax = 256;
  localparam int SettleCycles = 150;
  localparam int QuietLimit = 4000;
  localparam int HoldOffCycles = 400;

  typedef struct {
    logic [TimeW-1:0]         ts;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } sample_t;

  typedef struct {
    logic [TimeW-1:0] mean_time;
    logic [NormW-1:0] mean_norm;
  } means_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [LenW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TimeW-1:0] time_stamp = '0;
  logic signed [CoordW-1:0] coord_x = '0;
  logic signed [CoordW-1:0] coord_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TimeW-1:0] mean_time;
  logic [NormW-1:0] mean_norm;

  sample_t sample_queue[$];
  means_t pending_means[$];
  int mismatches = 0;
  bit steady = 1'b0;
  logic [TimeW-1:0] tick = '0;

  logic [LenW-1:0] win_q = LenReset;
  logic [TimeW-1:0] time_hist[WindowMax];
  logic [NormW-1:0] norm_hist[WindowMax];
  longint unsigned time_total = 0;
  longint unsigned norm_total = 0;
  int wr_slot = 0;
  int held = 0;

  sliding_average_of_vector_norm #(.WINDOW_MAX(WindowMax)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .time_stamp (time_stamp),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mean_time  (mean_time),
    .mean_norm  (mean_norm)
  );

  function automatic int span();
    int n;
    n = int'(win_q);
    if (n == 0) n = 1;
    if (n > WindowMax) n = WindowMax;
    return n;
  endfunction

  function automatic logic [31:0] magnitude(logic signed [CoordW-1:0] c);
    int v;
    v = c;
    if (v < 0) v = -v;
    return 32'(v);
  endfunction

  function automatic logic [NormW-1:0] int_root(logic [31:0] v);
    logic [NormW-1:0] r;
    logic [31:0] cand;
    r = '0;
    for (int i = NormW - 1; i >= 0; i--) begin
      cand = {16'd0, r | (16'd1 << i)};
      if (cand * cand <= v) r = cand[NormW-1:0];
    end
    return r;
  endfunction

  function automatic void predict_sample(sample_t s);
    int len;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [NormW-1:0] nrm;
    means_t m;
    len = span();
    ax = magnitude(s.cx);
    ay = magnitude(s.cy);
    nrm = int_root(ax * ax + ay * ay);
    if (wr_slot >= len) wr_slot = 0;
    if (held > len) held = len;
    if (held == len) begin
      time_total -= time_hist[wr_slot];
      norm_total -= norm_hist[wr_slot];
    end else begin
      held++;
    end
    time_hist[wr_slot] = s.ts;
    norm_hist[wr_slot] = nrm;
    time_total += s.ts;
    norm_total += nrm;
    wr_slot = (wr_slot + 1 >= len) ? 0 : wr_slot + 1;
    if (held == len) begin
      m.mean_time = TimeW'(time_total / longint'(len));
      m.mean_norm = NormW'(norm_total / longint'(len));
      pending_means = {pending_means, m};
    end
  endfunction

  function automatic logic signed [CoordW-1:0] pick_coord();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(4))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'hFFFF;
        3: return 16'h0000;
        default: return 16'h0001;
      endcase
    end
    return CoordW'($urandom);
  endfunction

  task automatic add_sample(logic [TimeW-1:0] ts, logic signed [CoordW-1:0] cx,
                            logic signed [CoordW-1:0] cy);
    sample_t s;
    s.ts = ts;
    s.cx = cx;
    s.cy = cy;
    sample_queue = {sample_queue, s};
  endtask

  task automatic random_samples(int count);
    logic [TimeW-1:0] ts;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: ts = $urandom;
        1: ts = 32'hFFFF_FFFF - $urandom_range(3);
        default: begin
          tick += $urandom_range(1, 5000);
          ts = tick;
        end
      endcase
      add_sample(ts, pick_coord(), pick_coord());
    end
  endtask

  task automatic settle();
    while (sample_queue.size() != 0 || in_valid || pending_means.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_window(logic [LenW-1:0] v);
    settle();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_q = v;
    time_total = 0;
    norm_total = 0;
    wr_slot = 0;
    held = 0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_sample(32'h0000_0000, 16'sh0000, 16'sh0000);
    add_sample(32'hFFFF_FFFF, 16'sh8000, 16'sh8000);
    add_sample(32'hFFFF_FFFF, 16'sh7FFF, 16'sh7FFF);
    add_sample(32'hFFFF_FFFF, 16'sh8000, 16'sh7FFF);
    add_sample(32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000);
    add_sample(32'h0000_0001, 16'shFFFF, 16'sh0001);
    add_sample(32'h0000_0002, 16'sh0003, 16'sh0004);
    add_sample(32'h0000_0003, 16'sh0000, 16'sh8000);
    add_sample(32'h0000_0004, 16'sh0001, 16'sh0000);
    add_sample(32'h0000_0005, 16'sh0000, 16'sh0001);
    add_sample(32'h0000_0006, 16'shFFFF, 16'shFFFF);
    add_sample(32'h0000_0007, 16'sh000C, 16'sh0005);
    add_sample(32'h8000_0000, 16'sh00FF, 16'shFF01);
    add_sample(32'h7FFF_FFFF, 16'sh5555, 16'shAAAA);
    add_sample(32'hAAAA_AAAA, 16'shAAAA, 16'sh5555);
    add_sample(32'h5555_5555, 16'sh8001, 16'sh7FFE);

    set_window(9'd1);
    random_samples(150);
    set_window(9'd0);
    random_samples(60);
    set_window(9'd256);
    random_samples(300);
    set_window(9'd511);
    random_samples(280);

    set_window(LenW'($urandom_range(2, 8)));
    steady = 1'b1;
    random_samples(150);
    settle();
    steady = 1'b0;

    for (int p = 0; p < 5; p++) begin
      set_window(LenW'($urandom_range(2, 20)));
      random_samples(90);
    end

    settle();
    if (mismatches == 0) begin
      $display("[sliding_average_of_vector_norm] OK");
    end else begin
      $display("[sliding_average_of_vector_norm] ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin : drive
    sample_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s.ts = time_stamp;
        s.cx = coord_x;
        s.cy = coord_y;
        predict_sample(s);
      end
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
          s = sample_queue.pop_front();
          time_stamp <= s.ts;
          coord_x <= s.cx;
          coord_y <= s.cy;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int words_seen = 0;
  int hold_left = 0;
  bit held_off = 1'b0;

  always @(posedge clk) begin : observe
    means_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (pending_means.size() == 0) begin
          $display("%0t unexpected word: mean_time %h mean_norm %h", $time,
                   mean_time, mean_norm);
          mismatches++;
        end else begin
          want = pending_means.pop_front();
          if (mean_time !== want.mean_time) begin
            $display("%0t mean_time expected %h got %h", $time, want.mean_time,
                     mean_time);
            mismatches++;
          end
          if (mean_norm !== want.mean_norm) begin
            $display("%0t mean_norm expected %h got %h", $time, want.mean_norm,
                     mean_norm);
            mismatches++;
          end
        end
      end
      // hold off once so the block backs up into its input
      if (!held_off && words_seen >= 100) begin
        held_off = 1'b1;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 36);
      end
    end
  end

  int quiet = 0;

  always @(posedge clk) begin : watchdog
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QuietLimit) begin
      $display("%0t no word moved for %0d cycles", $time, quiet);
      $display("[sliding_average_of_vector_norm] ERROR");
      $finish;
    end
  end

endmodule

>>> sliding_average_of_vector_norm.f
hdl/savn_pkg.sv
hdl/savn_ring.sv
hdl/savn_alu.sv
hdl/sliding_average_of_vector_norm.sv
dv/sliding_average_of_vector_norm_tb.sv
